### rtl/wtsp_pkg.sv
// Shared types, constants and saturation helpers for the world-to-screen projection block.
// Depends on nothing; imported by wtsp_div and world_to_screen_projection.
`default_nettype none

package wtsp_pkg;

    localparam int DATA_W        = 32;
    localparam int UDATA_W       = 31;
    localparam int FRAC_BITS_DEF = 16;
    // Wide enough for any sum of shifted products before saturation.
    localparam int SAT_W         = 66;
    localparam int COEF_IDX_W    = 5;
    localparam int CFG_IDX_W     = 3;
    // One input register plus one register per quotient bit.
    localparam int DIV_LAT       = DATA_W + 1;

    // Coefficient slot map.
    localparam int MV_COUNT   = 16;
    localparam int PR_COUNT   = 8;
    localparam int VP_COUNT   = 4;
    localparam int MV_IDX_W   = $clog2(MV_COUNT);
    localparam int PR_IDX_W   = $clog2(PR_COUNT);
    localparam int VP_IDX_W   = $clog2(VP_COUNT);
    localparam int SLOT_TR    = 12;
    localparam int SLOT_PR    = 16;
    localparam int SLOT_VP    = 24;
    localparam int SLOT_END   = 28;
    localparam int PR_ROW_Y   = 4;
    localparam int VP_X       = 0;
    localparam int VP_Y       = 1;
    localparam int VP_W       = 2;
    localparam int VP_H       = 3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_CAMERA_Z     = 3'd2,
        CFG_VIEW_SCALE_X = 3'd3,
        CFG_VIEW_SCALE_Y = 3'd4,
        CFG_VIEW_HEIGHT  = 3'd5
    } cfg_idx_t;

    typedef logic signed [DATA_W-1:0] sdata_t;
    typedef logic [DATA_W-1:0]        uword_t;

    localparam sdata_t SDATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam sdata_t SDATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Clamp a wide signed value into the 32-bit signed range.
    function automatic sdata_t sat32(logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] hi;
        sdata_t                r;
        hi = v[SAT_W-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            r = v[DATA_W-1:0];
        end else begin
            r = v[SAT_W-1] ? SDATA_MIN : SDATA_MAX;
        end
        return r;
    endfunction

    // Apply the sign to an unsigned quotient magnitude and saturate.
    function automatic sdata_t quot_sat(uword_t q, logic ovf, logic neg);
        sdata_t r;
        if (ovf || q[DATA_W-1]) begin
            r = neg ? SDATA_MIN : SDATA_MAX;
        end else begin
            r = neg ? -$signed(q) : $signed(q);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/wtsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the projection block.
// Depends on wtsp_pkg for data widths.
`default_nettype none

module wtsp_div #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            en,
    input  wtsp_pkg::uword_t num_mag,
    input  wtsp_pkg::uword_t den_mag,
    output wtsp_pkg::uword_t quo,
    output logic            ovf
);
    import wtsp_pkg::*;

    localparam int Q = DATA_W;

    // The dividend is num_mag scaled by 2^FRAC_BITS. Its bits above the quotient
    // width seed the remainder; overflow means the quotient needs more than Q bits.
    uword_t         rem_reg [Q];
    uword_t         num_reg [Q];
    uword_t         den_reg [Q];
    uword_t         quo_reg [Q+1];
    logic           ovf_reg [Q+1];

    logic [Q+1:0]   trial    [Q];
    logic           qbit     [Q];
    uword_t         rem_step [Q];

    always_comb begin
        for (int s = 0; s < Q; s++) begin
            trial[s]    = {1'b0, rem_reg[s], num_reg[s][Q-1]} - {2'b00, den_reg[s]};
            qbit[s]     = !trial[s][Q+1];
            rem_step[s] = qbit[s] ? trial[s][Q-1:0] : {rem_reg[s][Q-2:0], num_reg[s][Q-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_mag >> (Q - FRAC_BITS);
            num_reg[0] <= num_mag << FRAC_BITS;
            den_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            ovf_reg[0] <= ((num_mag >> (Q - FRAC_BITS)) >= den_mag);
            for (int s = 0; s < Q - 1; s++) begin
                rem_reg[s+1] <= rem_step[s];
                num_reg[s+1] <= num_reg[s] << 1;
                den_reg[s+1] <= den_reg[s];
            end
            for (int s = 0; s < Q; s++) begin
                quo_reg[s+1] <= {quo_reg[s][Q-2:0], qbit[s]};
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quo = quo_reg[Q];
    assign ovf = ovf_reg[Q];

endmodule

`default_nettype wire

### rtl/world_to_screen_projection.sv
// Top level of the world-to-screen point projection pipeline.
// Depends on wtsp_pkg and instantiates two wtsp_div dividers.
`default_nettype none

// Usage
// The s_ channel carries one item per transfer. An item with s_opcode set to load
// writes s_coef_value into coefficient slot s_coef_index and produces no result. An
// item with s_opcode set to project carries a world point and produces exactly one
// result on the m_ channel: screen x and y in view units, the eye depth, and a flag
// that is set when w was zero and the result was forced.
// The cfg_ port writes one of the camera position, view scale or view height registers
// per write; it is meant to be used while the pipeline is empty.
// Throughput is one item per clock while the receiver does not stall the output. The
// 33-stage divider (one quotient bit per stage after its input register) sits between
// stages E and F of nine arithmetic stages, A to I, which the output register follows.
// Coefficient loads travel down the pipeline in order with the points, and each
// group of coefficients (modelview, projection, viewport) is updated when the load
// passes the stage that reads it, so every point sees exactly the loads before it.
// Reset clears all valid bits, the coefficient store and the configuration registers
// to their defaults. When the receiver stalls, the whole pipeline holds; s_ready goes
// low only while a finished result waits in the output register and is not taken.
module world_to_screen_projection #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wtsp_pkg::uword_t                     cfg_wr_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [wtsp_pkg::COEF_IDX_W-1:0]      s_coef_index,
    input  wtsp_pkg::sdata_t                     s_coef_value,
    input  wtsp_pkg::sdata_t                     s_point_x,
    input  wtsp_pkg::sdata_t                     s_point_y,
    input  wtsp_pkg::sdata_t                     s_point_z,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output wtsp_pkg::sdata_t                     m_screen_x,
    output wtsp_pkg::sdata_t                     m_screen_y,
    output wtsp_pkg::sdata_t                     m_eye_depth,
    output logic                                 m_w_zero
);
    import wtsp_pkg::*;

    localparam int                 PW        = 2 * DATA_W - FRAC_BITS;
    localparam sdata_t             ONE       = sdata_t'(1) << FRAC_BITS;
    localparam sdata_t             NEG_ONE   = -ONE;
    localparam logic [UDATA_W-1:0] SCALE_ONE = UDATA_W'(1) << FRAC_BITS;

    typedef logic signed [PW-1:0] prod_t;

    typedef struct packed {
        logic                  op;
        logic [COEF_IDX_W-1:0] idx;
        sdata_t                val;
    } cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        sdata_t w;
        logic   wz;
        logic   negx;
        logic   negy;
    } side_t;

    // Fixed-point product, floored by FRAC_BITS.
    function automatic prod_t qmul(sdata_t a, sdata_t b);
        logic signed [2*DATA_W-1:0] p;
        p = a * b;
        return PW'(p >>> FRAC_BITS);
    endfunction

    // Viewport map: ((n + 1.0) * size) floored by FRAC_BITS + 1.
    function automatic prod_t vpmul(sdata_t n, sdata_t size);
        logic signed [DATA_W:0]   np1;
        logic signed [2*DATA_W:0] p;
        np1 = (DATA_W+1)'(n) + (DATA_W+1)'(ONE);
        p   = np1 * size;
        return PW'(p >>> (FRAC_BITS + 1));
    endfunction

    // ------------------------------------------------------------------
    // Flow control: every stage advances together unless the output
    // register holds a result that the receiver has not taken.
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    sdata_t             cam_x_reg, cam_y_reg, cam_z_reg;
    logic [UDATA_W-1:0] scale_x_reg, scale_y_reg, vheight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg   <= '0;
            cam_y_reg   <= '0;
            cam_z_reg   <= '0;
            scale_x_reg <= SCALE_ONE;
            scale_y_reg <= SCALE_ONE;
            vheight_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_CAMERA_X:     cam_x_reg   <= cfg_wr_data;
                CFG_CAMERA_Y:     cam_y_reg   <= cfg_wr_data;
                CFG_CAMERA_Z:     cam_z_reg   <= cfg_wr_data;
                CFG_VIEW_SCALE_X: scale_x_reg <= cfg_wr_data[UDATA_W-1:0];
                CFG_VIEW_SCALE_Y: scale_y_reg <= cfg_wr_data[UDATA_W-1:0];
                CFG_VIEW_HEIGHT:  vheight_reg <= cfg_wr_data[UDATA_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: register the transfer and subtract the camera position.
    // ------------------------------------------------------------------
    logic   a_valid_reg;
    cmd_t   a_cmd_reg;
    sdata_t a_d_reg  [3];
    sdata_t a_d_next [3];

    always_comb begin
        a_d_next[0] = sat32(SAT_W'(s_point_x) - SAT_W'(cam_x_reg));
        a_d_next[1] = sat32(SAT_W'(s_point_y) - SAT_W'(cam_y_reg));
        a_d_next[2] = sat32(SAT_W'(s_point_z) - SAT_W'(cam_z_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_cmd_reg <= '{op: s_opcode, idx: s_coef_index, val: s_coef_value};
            a_d_reg   <= a_d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: modelview products. The modelview copy is read here and
    // written by a load that sits in stage A.
    // ------------------------------------------------------------------
    sdata_t mv_reg [MV_COUNT];
    logic   a_load;

    assign a_load = a_valid_reg && (a_cmd_reg.op == OP_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MV_COUNT; i++) begin
                mv_reg[i] <= '0;
            end
        end else if (adv && a_load && (a_cmd_reg.idx < SLOT_PR)) begin
            mv_reg[a_cmd_reg.idx[MV_IDX_W-1:0]] <= a_cmd_reg.val;
        end
    end

    logic   b_valid_reg;
    cmd_t   b_cmd_reg;
    prod_t  b_prod_reg  [4][3];
    prod_t  b_prod_next [4][3];
    sdata_t b_tr_reg    [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                b_prod_next[r][c] = qmul(mv_reg[4*c+r], a_d_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_cmd_reg  <= a_cmd_reg;
            b_prod_reg <= b_prod_next;
            for (int r = 0; r < 4; r++) begin
                b_tr_reg[r] <= mv_reg[SLOT_TR+r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: eye coordinates.
    // ------------------------------------------------------------------
    logic   c_valid_reg;
    cmd_t   c_cmd_reg;
    sdata_t c_eye_reg  [4];
    sdata_t c_eye_next [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            c_eye_next[r] = sat32(SAT_W'(b_tr_reg[r]) + SAT_W'(b_prod_reg[r][0])
                                  + SAT_W'(b_prod_reg[r][1]) + SAT_W'(b_prod_reg[r][2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_cmd_reg <= b_cmd_reg;
            c_eye_reg <= c_eye_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: projection products and w. The projection copy is written
    // by a load that sits in stage C.
    // ------------------------------------------------------------------
    sdata_t pr_reg [PR_COUNT];
    logic   c_load;

    assign c_load = c_valid_reg && (c_cmd_reg.op == OP_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PR_COUNT; i++) begin
                pr_reg[i] <= '0;
            end
        end else if (adv && c_load && (c_cmd_reg.idx >= SLOT_PR)
                     && (c_cmd_reg.idx < SLOT_VP)) begin
            pr_reg[c_cmd_reg.idx[PR_IDX_W-1:0]] <= c_cmd_reg.val;
        end
    end

    logic   d_valid_reg;
    cmd_t   d_cmd_reg;
    prod_t  d_px_reg  [4];
    prod_t  d_py_reg  [4];
    prod_t  d_px_next [4];
    prod_t  d_py_next [4];
    sdata_t d_w_reg;
    sdata_t d_w_next;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            d_px_next[c] = qmul(pr_reg[c], c_eye_reg[c]);
            d_py_next[c] = qmul(pr_reg[PR_ROW_Y+c], c_eye_reg[c]);
        end
        d_w_next = sat32(-SAT_W'(c_eye_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_cmd_reg <= c_cmd_reg;
            d_px_reg  <= d_px_next;
            d_py_reg  <= d_py_next;
            d_w_reg   <= d_w_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: clip x and y, zero-w detect.
    // ------------------------------------------------------------------
    logic   e_valid_reg;
    cmd_t   e_cmd_reg;
    sdata_t e_cx_reg, e_cy_reg, e_w_reg;
    sdata_t e_cx_next, e_cy_next;
    logic   e_wz_reg;

    always_comb begin
        e_cx_next = sat32(SAT_W'(d_px_reg[0]) + SAT_W'(d_px_reg[1])
                          + SAT_W'(d_px_reg[2]) + SAT_W'(d_px_reg[3]));
        e_cy_next = sat32(SAT_W'(d_py_reg[0]) + SAT_W'(d_py_reg[1])
                          + SAT_W'(d_py_reg[2]) + SAT_W'(d_py_reg[3]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_cmd_reg <= d_cmd_reg;
            e_cx_reg  <= e_cx_next;
            e_cy_reg  <= e_cy_next;
            e_w_reg   <= d_w_reg;
            e_wz_reg  <= (d_w_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Divide clip x and y by w on magnitudes; signs and the rest of the
    // item ride along in a matching delay line.
    // ------------------------------------------------------------------
    uword_t cx_mag, cy_mag, w_mag;
    uword_t quo_x, quo_y;
    logic   ovf_x, ovf_y;

    assign cx_mag = e_cx_reg[DATA_W-1] ? uword_t'(-e_cx_reg) : uword_t'(e_cx_reg);
    assign cy_mag = e_cy_reg[DATA_W-1] ? uword_t'(-e_cy_reg) : uword_t'(e_cy_reg);
    assign w_mag  = e_w_reg[DATA_W-1]  ? uword_t'(-e_w_reg)  : uword_t'(e_w_reg);

    wtsp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .aclk    (aclk),
        .en      (adv),
        .num_mag (cx_mag),
        .den_mag (w_mag),
        .quo     (quo_x),
        .ovf     (ovf_x)
    );

    wtsp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .aclk    (aclk),
        .en      (adv),
        .num_mag (cy_mag),
        .den_mag (w_mag),
        .quo     (quo_y),
        .ovf     (ovf_y)
    );

    logic  side_valid_reg [DIV_LAT];
    side_t side_reg       [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                side_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            side_valid_reg[0] <= e_valid_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                side_valid_reg[k] <= side_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{cmd:  e_cmd_reg,
                             w:    e_w_reg,
                             wz:   e_wz_reg,
                             negx: e_cx_reg[DATA_W-1] ^ e_w_reg[DATA_W-1],
                             negy: e_cy_reg[DATA_W-1] ^ e_w_reg[DATA_W-1]};
            for (int k = 1; k < DIV_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: signed, saturated normalized coordinates.
    // ------------------------------------------------------------------
    side_t  div_side;
    logic   f_valid_reg;
    cmd_t   f_cmd_reg;
    sdata_t f_nx_reg, f_ny_reg, f_w_reg;
    logic   f_wz_reg;

    assign div_side = side_reg[DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= side_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_cmd_reg <= div_side.cmd;
            f_nx_reg  <= quot_sat(quo_x, ovf_x, div_side.negx);
            f_ny_reg  <= quot_sat(quo_y, ovf_y, div_side.negy);
            f_w_reg   <= div_side.w;
            f_wz_reg  <= div_side.wz;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: viewport products. The viewport copy is written by a load
    // that sits in stage F; loads leave the pipeline here.
    // ------------------------------------------------------------------
    sdata_t vp_reg [VP_COUNT];
    logic   f_load;

    assign f_load = f_valid_reg && (f_cmd_reg.op == OP_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VP_COUNT; i++) begin
                vp_reg[i] <= '0;
            end
        end else if (adv && f_load && (f_cmd_reg.idx >= SLOT_VP)
                     && (f_cmd_reg.idx < SLOT_END)) begin
            vp_reg[f_cmd_reg.idx[VP_IDX_W-1:0]] <= f_cmd_reg.val;
        end
    end

    logic   g_valid_reg;
    prod_t  g_vx_reg, g_vy_reg;
    sdata_t g_offx_reg, g_offy_reg, g_w_reg;
    logic   g_wz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= f_valid_reg && (f_cmd_reg.op == OP_PROJECT);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_vx_reg   <= vpmul(f_nx_reg, vp_reg[VP_W]);
            g_vy_reg   <= vpmul(f_ny_reg, vp_reg[VP_H]);
            g_offx_reg <= vp_reg[VP_X];
            g_offy_reg <= vp_reg[VP_Y];
            g_w_reg    <= f_w_reg;
            g_wz_reg   <= f_wz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: window coordinates.
    // ------------------------------------------------------------------
    logic   h_valid_reg;
    sdata_t h_wx_reg, h_wy_reg, h_w_reg;
    logic   h_wz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (adv) begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_wx_reg <= sat32(SAT_W'(g_vx_reg) + SAT_W'(g_offx_reg));
            h_wy_reg <= sat32(SAT_W'(g_vy_reg) + SAT_W'(g_offy_reg));
            h_w_reg  <= g_w_reg;
            h_wz_reg <= g_wz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage I: scale to view units.
    // ------------------------------------------------------------------
    logic   i_valid_reg;
    prod_t  i_sx_reg, i_sy_reg;
    sdata_t i_w_reg;
    logic   i_wz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg <= 1'b0;
        end else if (adv) begin
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i_sx_reg <= qmul(h_wx_reg, $signed({1'b0, scale_x_reg}));
            i_sy_reg <= qmul(h_wy_reg, $signed({1'b0, scale_y_reg}));
            i_w_reg  <= h_w_reg;
            i_wz_reg <= h_wz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: flip y against the view height, or force the
    // zero-w result.
    // ------------------------------------------------------------------
    sdata_t m_screen_x_reg, m_screen_y_reg, m_eye_depth_reg;
    sdata_t m_screen_x_next, m_screen_y_next, m_eye_depth_next;
    logic   m_w_zero_reg, m_w_zero_next;

    always_comb begin
        if (i_wz_reg) begin
            m_screen_x_next  = '0;
            m_screen_y_next  = '0;
            m_eye_depth_next = NEG_ONE;
            m_w_zero_next    = 1'b1;
        end else begin
            m_screen_x_next  = sat32(SAT_W'(i_sx_reg));
            m_screen_y_next  = sat32($signed(SAT_W'(vheight_reg))
                                     - SAT_W'(sat32(SAT_W'(i_sy_reg))));
            m_eye_depth_next = i_w_reg;
            m_w_zero_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_screen_x_reg  <= m_screen_x_next;
            m_screen_y_reg  <= m_screen_y_next;
            m_eye_depth_reg <= m_eye_depth_next;
            m_w_zero_reg    <= m_w_zero_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_screen_x  = m_screen_x_reg;
    assign m_screen_y  = m_screen_y_reg;
    assign m_eye_depth = m_eye_depth_reg;
    assign m_w_zero    = m_w_zero_reg;

endmodule

`default_nettype wire
